/* rtl/greedy_box_suppression_assert.svh */
// assertion macros for the box suppression block
// no dependencies
`ifndef GREEDY_BOX_SUPPRESSION_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_ASSERT_SVH
// implication checked every edge outside reset
`define GBS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication outside reset
`define GBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* rtl/gbs_pkg.sv */
// shared types and constants for greedy box suppression
// no dependencies
package gbs_pkg;
   localparam int SET_DEPTH_DEF  = 256;
   localparam int COORD_BITS_DEF = 16;
   localparam logic [15:0] SCORE_THR_RST   = 16'd6554;
   localparam logic [8:0]  OVERLAP_THR_RST = 9'd115;
   localparam logic [0:0] CSR_SCORE_THR   = 1'b0;
   localparam logic [0:0] CSR_OVERLAP_THR = 1'b1;
   localparam logic [1:0] VERDICT_KEPT       = 2'd0;
   localparam logic [1:0] VERDICT_LOW_SCORE  = 2'd1;
   localparam logic [1:0] VERDICT_SUPPRESSED = 2'd2;
   localparam logic [1:0] VERDICT_TOO_LONG   = 2'd3;

   typedef struct packed {
      logic [15:0] box_xmin;
      logic [15:0] box_ymin;
      logic [15:0] box_xmax;
      logic [15:0] box_ymax;
      logic [15:0] box_score;
      logic        set_end;
   } req_type;

   typedef struct packed {
      logic [7:0] box_index;
      logic [1:0] verdict;
      logic [8:0] kept_total;
      logic       result_last;
   } rsp_type;

   // front to back: one classified beat
   typedef struct packed {
      logic [15:0] xmin;
      logic [15:0] ymin;
      logic [15:0] xmax;
      logic [15:0] ymax;
      logic        examine;
      logic [1:0]  pre_verdict;
      logic [7:0]  box_index;
      logic        set_end;
   } job_type;
endpackage

/* rtl/gbs_ram.sv */
// generic single-port-write, one-read ram with registered read
// no dependencies
module gbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* rtl/gbs_front.sv */
// front end: accepts boxes, checks score and set position, queues jobs
// uses gbs_pkg
module gbs_front import gbs_pkg::*; #(
   parameter int SET_DEPTH  = SET_DEPTH_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   input  logic [15:0] score_thr,
   output logic        job_valid,
   output job_type     job,
   input  logic        job_take
);
   localparam int PW = $clog2(SET_DEPTH + 1);
   localparam logic [15:0] CMASK = 16'((64'd1 << COORD_BITS) - 64'd1);

   logic [PW-1:0] pos_ff, pos_in;
   job_type       q_ff [2];
   job_type       q_in_entry;
   logic [1:0]    cnt_ff;
   logic          rd_ff, wr_ff;
   logic          acc, too_long;

   assign req_full  = (cnt_ff == 2'd2);
   assign acc       = req_push && !req_full;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ff];
   assign too_long  = (pos_ff >= PW'(SET_DEPTH));

   always_comb begin
      q_in_entry.xmin = req_data.box_xmin & CMASK;
      q_in_entry.ymin = req_data.box_ymin & CMASK;
      q_in_entry.xmax = req_data.box_xmax & CMASK;
      q_in_entry.ymax = req_data.box_ymax & CMASK;
      q_in_entry.examine = !too_long && (req_data.box_score > score_thr);
      q_in_entry.pre_verdict = too_long ? VERDICT_TOO_LONG : VERDICT_LOW_SCORE;
      q_in_entry.box_index = (pos_ff > PW'(255)) ? 8'd255 : 8'(pos_ff);
      q_in_entry.set_end = req_data.set_end;
      pos_in = pos_ff;
      if (acc) begin
         if (req_data.set_end) pos_in = '0;
         else if (!too_long) pos_in = pos_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (acc) q_ff[wr_ff] <= q_in_entry;
      if (reset) begin
         pos_ff <= '0;
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (acc) wr_ff <= !wr_ff;
         if (job_take && job_valid) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(acc) - 2'(job_take && job_valid);
      end
   end
endmodule

/* rtl/gbs_back.sv */
// back end: compares an examined job with the kept boxes until one overlaps it, stores kept boxes, emits verdict
// uses gbs_pkg, gbs_ram, assertion macros
`include "greedy_box_suppression_assert.svh"
module gbs_back import gbs_pkg::*; #(
   parameter int SET_DEPTH  = SET_DEPTH_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_take,
   input  logic [8:0] overlap_thr,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data
);
   localparam int AW = $clog2(SET_DEPTH);
   localparam int KW = $clog2(SET_DEPTH + 1);
   // coordinates never carry more than the 16 bits of a job field
   localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;
   localparam int AR = 2 * CW;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001, ST_RD = 6'b000010, ST_CMP1 = 6'b000100,
      ST_CMP2 = 6'b001000, ST_CMP3 = 6'b010000, ST_DONE = 6'b100000
   } state_type;

   state_type      st_ff, st_in;
   job_type        job_ff;
   logic [KW-1:0]  kept_ff;
   logic [KW-1:0]  kept_nx;
   logic [KW-1:0]  k_ff;
   logic [AR-1:0]  area_ff;
   logic           hit_ff;
   logic [1:0]     verd_ff;
   rsp_type        out_ff;
   logic           out_valid_ff;
   logic [4*CW-1:0] rd_box;
   logic [AR-1:0]   rd_area;
   logic [CW-1:0]  ix_ff, iy_ff;
   logic [AR-1:0]  inter_ff, sarea_ff;
   logic [AR+9:0]  lhs, rhs;
   logic [CW-1:0]  sx0, sy0, sx1, sy1, lo_x, hi_x, lo_y, hi_y;
   logic           wr_en;

   gbs_ram #(.WIDTH(4 * CW), .DEPTH(SET_DEPTH)) u_box_ram (
      .clock, .wr_en, .wr_addr(kept_ff[AW-1:0]),
      .wr_data({job_ff.xmin[CW-1:0], job_ff.ymin[CW-1:0],
                job_ff.xmax[CW-1:0], job_ff.ymax[CW-1:0]}),
      .rd_addr(k_ff[AW-1:0]), .rd_data(rd_box)
   );
   gbs_ram #(.WIDTH(AR), .DEPTH(SET_DEPTH)) u_area_ram (
      .clock, .wr_en, .wr_addr(kept_ff[AW-1:0]), .wr_data(area_ff),
      .rd_addr(k_ff[AW-1:0]), .rd_data(rd_area)
   );

   assign job_take  = (st_ff == ST_IDLE) && job_valid;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign {sx0, sy0, sx1, sy1} = rd_box;
   assign lo_x = (job_ff.xmin[CW-1:0] > sx0) ? job_ff.xmin[CW-1:0] : sx0;
   assign hi_x = (job_ff.xmax[CW-1:0] < sx1) ? job_ff.xmax[CW-1:0] : sx1;
   assign lo_y = (job_ff.ymin[CW-1:0] > sy0) ? job_ff.ymin[CW-1:0] : sy0;
   assign hi_y = (job_ff.ymax[CW-1:0] < sy1) ? job_ff.ymax[CW-1:0] : sy1;
   assign lhs = {2'b00, inter_ff, 8'd0};
   assign rhs = (AR+10)'(overlap_thr) *
                ((AR+10)'(area_ff) + (AR+10)'(sarea_ff) - (AR+10)'(inter_ff));
   assign wr_en = (st_ff == ST_DONE) && (verd_ff == VERDICT_KEPT) && !hit_ff
                  && job_ff.examine && !out_valid_ff;
   assign kept_nx = wr_en ? kept_ff + KW'(1) : kept_ff;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (job_valid) st_in = ST_RD;
         ST_RD:   st_in = (!job_ff.examine || hit_ff || k_ff >= kept_ff)
                          ? ST_DONE : ST_CMP1;
         ST_CMP1: st_in = ST_CMP2;
         ST_CMP2: st_in = ST_CMP3;
         ST_CMP3: st_in = ST_RD;
         ST_DONE: if (!out_valid_ff) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: if (job_valid) begin
            job_ff <= job;
            k_ff   <= '0;
            area_ff <= AR'((job.xmax[CW-1:0] > job.xmin[CW-1:0]
                            ? job.xmax[CW-1:0] - job.xmin[CW-1:0] : '0)) *
                       AR'((job.ymax[CW-1:0] > job.ymin[CW-1:0]
                            ? job.ymax[CW-1:0] - job.ymin[CW-1:0] : '0));
         end
         ST_CMP1: begin
            ix_ff <= (hi_x > lo_x) ? hi_x - lo_x : '0;
            iy_ff <= (hi_y > lo_y) ? hi_y - lo_y : '0;
            sarea_ff <= rd_area;
         end
         ST_CMP2: inter_ff <= AR'(ix_ff) * AR'(iy_ff);
         default: ;
      endcase
      if (reset) begin
         st_ff <= ST_IDLE;
         kept_ff <= '0;
         hit_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         verd_ff <= VERDICT_KEPT;
      end else begin
         st_ff <= st_in;
         if (out_valid_ff && rsp_pop) out_valid_ff <= 1'b0;
         if (st_ff == ST_IDLE) hit_ff <= 1'b0;
         if (st_ff == ST_CMP3) begin
            if (lhs > rhs) hit_ff <= 1'b1;
            k_ff <= k_ff + KW'(1);
         end
         if (st_ff == ST_RD && st_in == ST_DONE) begin
            if (!job_ff.examine) verd_ff <= job_ff.pre_verdict;
            else if (hit_ff) verd_ff <= VERDICT_SUPPRESSED;
            else if (kept_ff >= KW'(SET_DEPTH)) verd_ff <= VERDICT_TOO_LONG;
            else verd_ff <= VERDICT_KEPT;
         end
         if (st_ff == ST_DONE && !out_valid_ff) begin
            out_valid_ff <= 1'b1;
            out_ff.box_index <= job_ff.box_index;
            out_ff.verdict <= verd_ff;
            out_ff.kept_total <= (int'(kept_nx) > 511) ? 9'd511 : 9'(kept_nx);
            out_ff.result_last <= job_ff.set_end;
            if (job_ff.set_end) kept_ff <= '0;
            else kept_ff <= kept_nx;
         end
      end
   end

   `GBS_ASSERT_IMP(a_kept_bound, clock, reset, 1'b1, kept_ff <= KW'(SET_DEPTH))
   `GBS_ASSERT_IMP(a_onehot_st, clock, reset, 1'b1, $onehot(st_ff))
   `GBS_ASSERT_NEXT(a_pop_clears, clock, reset, out_valid_ff && rsp_pop,
      !out_valid_ff)
   `GBS_ASSERT_IMP(a_write_kept, clock, reset, wr_en, kept_ff < KW'(SET_DEPTH))
endmodule

/* rtl/greedy_box_suppression.sv */
// greedy box suppression, top level: front end, back end and config registers
// uses gbs_pkg, gbs_front, gbs_back
// the back end handles one box at a time; the front queue holds accepted boxes while it is busy
// the shared compare unit walks the kept boxes for each examined box, stopping at the first hit
// reset: synchronous active high, clears counts, queue, thresholds to defaults
module greedy_box_suppression import gbs_pkg::*; #(
   parameter int SET_DEPTH  = SET_DEPTH_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data
);
   // threshold registers
   logic [15:0] score_thr_ff;
   logic [8:0]  overlap_thr_ff;
   logic        job_valid, job_take;
   job_type     job;

   always_ff @(posedge clock) begin
      if (reset) begin
         score_thr_ff   <= SCORE_THR_RST;
         overlap_thr_ff <= OVERLAP_THR_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SCORE_THR:   score_thr_ff <= csr_wr_data;
            CSR_OVERLAP_THR: overlap_thr_ff <= csr_wr_data[8:0];
            default: ;
         endcase
      end
   end

   // front classifies each beat and queues it
   gbs_front #(.SET_DEPTH(SET_DEPTH), .COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .score_thr(score_thr_ff), .job_valid, .job, .job_take
   );

   // back walks the kept store one entry per pass
   gbs_back #(.SET_DEPTH(SET_DEPTH), .COORD_BITS(COORD_BITS)) u_back (
      .clock, .reset, .job_valid, .job, .job_take,
      .overlap_thr(overlap_thr_ff), .rsp_empty, .rsp_pop, .rsp_data
   );
endmodule
